// ----- hw/rtl/dqs_pkg.sv -----
// Shared constants, command codes and the cell control struct for the deque.
package dqs_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;

  localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [2:0] OP_POP_BACK   = 3'd2;
  localparam logic [2:0] OP_POP_FRONT  = 3'd3;
  localparam logic [2:0] OP_SORT       = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [2:0] CMD_HOLD       = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd2;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [2:0] CMD_SORT       = 3'd4;

  typedef struct packed {
    logic [2:0]               cmd;
    logic                     phase;
    logic                     desc;
    logic [CNT_W-1:0]         count;
    logic signed [WORD_W-1:0] value;
  } ctrl_t;

endpackage

// ----- hw/rtl/dqs_cell.sv -----
// One deque cell: holds one word, shifts with its neighbors, compare-exchanges in sort.
module dqs_cell (
  input  logic                              clk,
  input  dqs_pkg::ctrl_t                    ctrl,
  input  logic [dqs_pkg::IDX_W-1:0]         idx,
  input  logic signed [dqs_pkg::WORD_W-1:0] left,
  input  logic signed [dqs_pkg::WORD_W-1:0] right,
  output logic signed [dqs_pkg::WORD_W-1:0] word
);
  import dqs_pkg::*;

  logic signed [WORD_W-1:0] word_next;
  logic [CNT_W-1:0]         idx_ext;
  logic                     is_lower;
  logic                     is_upper;
  logic                     right_less;
  logic                     left_less;

  assign idx_ext = CNT_W'(idx);
  // odd-even transposition: pair (i, i+1) where i[0] matches the phase
  assign is_lower = (idx[0] == ctrl.phase) && ((idx_ext + CNT_W'(1)) < ctrl.count);
  assign is_upper = (idx[0] != ctrl.phase) && (idx != '0) && (idx_ext < ctrl.count);
  assign right_less = right < word;
  assign left_less  = left < word;

  always_comb begin
    word_next = word;
    unique case (ctrl.cmd)
      CMD_HOLD: word_next = word;
      CMD_PUSH_BACK: begin
        if (idx_ext == ctrl.count) word_next = ctrl.value;
      end
      CMD_PUSH_FRONT: word_next = (idx == '0) ? ctrl.value : left;
      CMD_POP_FRONT: word_next = right;
      CMD_SORT: begin
        if (is_lower) begin
          // lower slot keeps min when ascending, max when descending
          word_next = (right_less ^ ctrl.desc) ? right : word;
        end else if (is_upper) begin
          word_next = (left_less ^ ctrl.desc) ? word : left;
        end
      end
      default: word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

// ----- hw/rtl/deque_with_inplace_sort.sv -----
// Top level: bounded deque built from a row of shifting cells, with in-place sort.
//
// Usage: drive op, value and descending and raise start; the word is taken at a
// rising edge where start is high and busy is low. Each operation gives exactly
// one result on popped_value, status and occupancy, shown for one cycle with
// result_valid high; the receiver cannot stall and must take it then.
// Cells hold the words in front-to-back order: cell 0 is the front.
// For push back, push front, pop back, pop front and unused codes the result
// appears the cycle after acceptance, and busy stays low, so a new word can be
// taken every cycle.
// A sort runs DEPTH odd-even transposition passes over the cell row, one pass
// per cycle with alternate neighbor pairs compared at once. busy is high while
// the passes run, and the result is shown once the last pass is written.
// Pop on empty returns 0 with status 1; push on full is dropped with status 2.
// Reset empties the deque and clears busy and result_valid; cell contents are
// left as they are and are never read before written.
module deque_with_inplace_sort (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        op,
  input  logic signed [dqs_pkg::WORD_W-1:0] value,
  input  logic                              descending,
  output logic                              result_valid,
  output logic signed [dqs_pkg::WORD_W-1:0] popped_value,
  output logic [1:0]                        status,
  output logic [dqs_pkg::CNT_W-1:0]         occupancy
);
  import dqs_pkg::*;

  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic [CNT_W-1:0]         count_m1;
  logic [IDX_W-1:0]         sort_cnt;
  logic                     sort_desc;
  logic                     accept;
  logic                     full;
  logic                     empty;
  ctrl_t                    ctrl;
  logic signed [WORD_W-1:0] cell_word [DEPTH];
  logic signed [WORD_W-1:0] pop_word;
  logic [1:0]               status_next;

  assign accept   = start && !busy;
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign count_m1 = count - CNT_W'(1);

  always_comb begin
    ctrl.cmd    = CMD_HOLD;
    ctrl.phase  = sort_cnt[0];
    ctrl.desc   = sort_desc;
    ctrl.count  = count;
    ctrl.value  = value;
    count_next  = count;
    status_next = ST_DONE;
    pop_word    = '0;
    if (busy) begin
      ctrl.cmd = CMD_SORT;
    end else if (accept) begin
      case (op) inside
        OP_PUSH_BACK, OP_PUSH_FRONT: begin
          if (full) begin
            status_next = ST_FULL;
          end else begin
            ctrl.cmd   = (op == OP_PUSH_BACK) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
            count_next = count + CNT_W'(1);
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            status_next = ST_EMPTY;
          end else begin
            pop_word   = cell_word[count_m1[IDX_W-1:0]];
            count_next = count_m1;
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            status_next = ST_EMPTY;
          end else begin
            ctrl.cmd   = CMD_POP_FRONT;
            pop_word   = cell_word[0];
            count_next = count_m1;
          end
        end
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_W-1:0] left_w;
    logic signed [WORD_W-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_word[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_word[i+1];
    end
    dqs_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .idx   (IDX_W'(i)),
      .left  (left_w),
      .right (right_w),
      .word  (cell_word[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      busy         <= 1'b0;
      sort_cnt     <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      count        <= count_next;
      if (busy) begin
        sort_cnt <= sort_cnt + IDX_W'(1);
        if (sort_cnt == IDX_W'(DEPTH - 1)) begin
          busy         <= 1'b0;
          result_valid <= 1'b1;
        end
      end else if (accept) begin
        if (op == OP_SORT) begin
          busy     <= 1'b1;
          sort_cnt <= '0;
        end else begin
          result_valid <= 1'b1;
        end
      end
    end
  end

  // result payload and sort direction
  always_ff @(posedge clk) begin
    if (accept) begin
      popped_value <= pop_word;
      status       <= status_next;
      occupancy    <= count_next;
      sort_desc    <= descending;
    end
  end

endmodule
